// ===== hw/rtl/ycs_pkg.sv =====
// ----------------------------------------------------------------------------
// ycs_pkg
// Shared types, register codes and fixed-point coefficients of the
// color converter with chroma subsampling.
// ----------------------------------------------------------------------------
package ycs_pkg;

  // kind of arithmetic a request needs in the back end
  typedef enum logic [1:0] {
    OP_PASS,
    OP_FWD,
    OP_INV
  } op_e;

  // configuration port
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 13;
  localparam int ModeW      = 3;
  localparam int LineWidthW = 13;

  localparam logic [CfgIdxW-1:0] REG_MODE       = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH = 1'b1;

  localparam logic [ModeW-1:0] MODE_PASS   = 3'd0;
  localparam logic [ModeW-1:0] MODE_FWD444 = 3'd1;
  localparam logic [ModeW-1:0] MODE_FWD422 = 3'd2;
  localparam logic [ModeW-1:0] MODE_FWD420 = 3'd3;
  localparam logic [ModeW-1:0] MODE_INV444 = 3'd4;
  localparam logic [ModeW-1:0] MODE_INV422 = 3'd5;
  localparam logic [ModeW-1:0] MODE_INV420 = 3'd6;

  localparam logic [LineWidthW-1:0] LINE_WIDTH_RST = 13'd640;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPtrW  = $clog2(QDEPTH);
  localparam int QCntW  = $clog2(QDEPTH + 1);

  // fixed-point datapath, Q16 coefficients
  localparam int CoefW = 18;
  localparam int TermW = 28;
  localparam int FracW = 16;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [TermW-1:0] term_t;

  // one classified request from the front end
  typedef struct packed {
    op_e        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       b_valid;
    logic       c_valid;
    logic       row_end;
  } item_t;

  // coefficient for output channel sel[3:2] and input operand sel[1:0]
  function automatic coef_t coef(op_e op, logic [3:0] sel);
    coef_t k;
    k = '0;
    case (op)
      OP_FWD: begin
        case (sel)
          4'h0: k = 18'sd7471;
          4'h1: k = 18'sd38470;
          4'h2: k = 18'sd19595;
          4'h4: k = 18'sd32768;
          4'h5: k = -18'sd21710;
          4'h6: k = -18'sd11058;
          4'h8: k = -18'sd5329;
          4'h9: k = -18'sd27439;
          4'hA: k = 18'sd32768;
          default: k = '0;
        endcase
      end
      OP_INV: begin
        case (sel)
          4'h0: k = 18'sd65536;
          4'h1: k = 18'sd116130;
          4'h4: k = 18'sd65536;
          4'h5: k = -18'sd22553;
          4'h6: k = -18'sd46802;
          4'h8: k = 18'sd65536;
          4'hA: k = 18'sd91881;
          default: k = '0;
        endcase
      end
      OP_PASS: begin
        case (sel)
          4'h0: k = 18'sd65536;
          4'h5: k = 18'sd65536;
          4'hA: k = 18'sd65536;
          default: k = '0;
        endcase
      end
      default: k = '0;
    endcase
    return k;
  endfunction

  // chroma bias of the forward transform
  function automatic term_t offset(op_e op, logic [1:0] row);
    term_t o;
    o = '0;
    if ((op == OP_FWD) && (row != 2'd0)) begin
      o = 28'sd8388608;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/ycs_ram.sv =====
// ----------------------------------------------------------------------------
// ycs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ycs_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port, read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ycs_fifo.sv =====
// ----------------------------------------------------------------------------
// ycs_fifo
// Short request queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ycs_fifo import ycs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t            mem_q [QDEPTH];
  logic [QPtrW-1:0] wptr_q;
  logic [QPtrW-1:0] rptr_q;
  logic [QCntW-1:0] cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign full_o  = (cnt_q == QCntW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

endmodule

// ===== hw/rtl/ycs_front.sv =====
// ----------------------------------------------------------------------------
// ycs_front
// Accepts pixels, tracks the raster position, classifies each request by
// mode and resolves held and line-stored chroma before queueing it.
// ----------------------------------------------------------------------------
module ycs_front import ycs_pkg::*; #(
  parameter int MaxWidth = 4096,
  localparam int ColW = $clog2(MaxWidth),
  localparam int LineDepth = (MaxWidth + 1) / 2,
  localparam int AddrW = (LineDepth > 1) ? $clog2(LineDepth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push_i,
  input  logic                frame_start_i,
  input  logic [7:0]          chan_a_i,
  input  logic [7:0]          chan_b_i,
  input  logic [7:0]          chan_c_i,
  output logic                full_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output item_t               q_item_o
);

  localparam int WW = LineWidthW + 1;
  localparam logic [WW-1:0] WidMax = WW'(MaxWidth);
  localparam logic [WW-1:0] WidMin = WW'(2);

  logic [ModeW-1:0]      mode_q;
  logic [LineWidthW-1:0] line_width_q;
  logic [ColW-1:0]       col_q;
  logic                  odd_q;
  logic [15:0]           held_q;

  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_a_q, s1_b_q, s1_c_q;
  logic       s1_bv_q, s1_cv_q, s1_last_q;
  logic       s1_use_held_q, s1_take_new_q, s1_line_rd_q;

  logic            accept, s1_adv;
  logic [ColW-1:0] col, col_d;
  logic            odd, even, last;
  logic [WW-1:0]   wid_eff, col_inc;
  logic [AddrW-1:0] pair;
  op_e             op;
  logic            bv, cv, use_held, take_new, line_wr, line_rd;
  logic [15:0]     rdata, chroma;

  // handshake: the stage register frees up when the queue takes its request
  assign s1_adv = s1_valid_q & ~q_full_i;
  assign full_o = s1_valid_q & q_full_i;
  assign accept = push_i & ~full_o;

  // raster position of the incoming pixel
  assign col  = frame_start_i ? '0 : col_q;
  assign odd  = frame_start_i ? 1'b0 : odd_q;
  assign even = ~col[0];
  assign pair = AddrW'(col >> 1);

  // effective line width, clamped to 2..MaxWidth
  always_comb begin
    wid_eff = {1'b0, line_width_q};
    if (wid_eff < WidMin) begin
      wid_eff = WidMin;
    end else if (wid_eff > WidMax) begin
      wid_eff = WidMax;
    end
  end

  assign col_inc = WW'(col) + 1'b1;
  assign last    = (col_inc >= wid_eff);
  assign col_d   = last ? '0 : col_inc[ColW-1:0];

  // mode decode: arithmetic kind, kept samples and chroma source
  always_comb begin
    op       = OP_PASS;
    bv       = 1'b1;
    cv       = 1'b1;
    use_held = 1'b0;
    take_new = 1'b0;
    line_wr  = 1'b0;
    line_rd  = 1'b0;
    case (mode_q)
      MODE_FWD444: begin
        op = OP_FWD;
      end
      MODE_FWD422: begin
        op = OP_FWD;
        bv = even;
        cv = even;
      end
      MODE_FWD420: begin
        op = OP_FWD;
        bv = even & ~odd;
        cv = even & odd;
      end
      MODE_INV444: begin
        op = OP_INV;
      end
      MODE_INV422: begin
        op       = OP_INV;
        use_held = 1'b1;
        take_new = even;
      end
      MODE_INV420: begin
        op       = OP_INV;
        use_held = 1'b1;
        take_new = even & ~odd;
        line_wr  = even & ~odd;
        line_rd  = even & odd;
      end
      default: begin
        op = OP_PASS;
      end
    endcase
  end

  // chroma line store for the odd row in inverse 420
  ycs_ram #(
    .Width (16),
    .Depth (LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept & line_wr),
    .waddr_i (pair),
    .wdata_i ({chan_c_i, chan_b_i}),
    .re_i    (accept & line_rd),
    .raddr_i (pair),
    .rdata_o (rdata)
  );

  // configuration registers and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_PASS;
      line_width_q <= LINE_WIDTH_RST;
      col_q        <= '0;
      odd_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:       mode_q       <= cfg_wdata_i[ModeW-1:0];
          REG_LINE_WIDTH: line_width_q <= cfg_wdata_i[LineWidthW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        odd_q <= last ? ~odd : odd;
      end
    end
  end

  // stage register valid and held chroma
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      held_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && (s1_take_new_q || s1_line_rd_q)) begin
        held_q <= chroma;
      end
    end
  end

  // stage register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= op;
      s1_a_q        <= chan_a_i;
      s1_b_q        <= chan_b_i;
      s1_c_q        <= chan_c_i;
      s1_bv_q       <= bv;
      s1_cv_q       <= cv;
      s1_last_q     <= last;
      s1_use_held_q <= use_held;
      s1_take_new_q <= take_new;
      s1_line_rd_q  <= line_rd;
    end
  end

  // chroma source: line store, this pixel, or the held pair value
  always_comb begin
    if (s1_line_rd_q) begin
      chroma = rdata;
    end else if (s1_take_new_q) begin
      chroma = {s1_c_q, s1_b_q};
    end else begin
      chroma = held_q;
    end
  end

  // request into the queue
  always_comb begin
    q_item_o.op      = s1_op_q;
    q_item_o.a       = s1_a_q;
    q_item_o.b       = s1_use_held_q ? chroma[7:0]  : s1_b_q;
    q_item_o.c       = s1_use_held_q ? chroma[15:8] : s1_c_q;
    q_item_o.b_valid = s1_bv_q;
    q_item_o.c_valid = s1_cv_q;
    q_item_o.row_end = s1_last_q;
  end

  assign q_push_o = s1_adv;

endmodule

// ===== hw/rtl/ycs_back.sv =====
// ----------------------------------------------------------------------------
// ycs_back
// Fixed-point color transform: a product stage and a sum, floor and clamp
// stage that ends in the result register.
// ----------------------------------------------------------------------------
module ycs_back import ycs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_a_o,
  output logic [7:0] out_b_o,
  output logic [7:0] out_c_o,
  output logic       b_valid_o,
  output logic       c_valid_o,
  output logic       row_end_o
);

  logic signed [8:0] opnd [3];
  term_t             term_d [3][3];
  term_t             p_term_q [3][3];
  logic              p_valid_q, p_bv_q, p_cv_q, p_last_q;

  term_t             sum [3];
  logic signed [TermW-FracW-1:0] whole [3];
  logic [7:0]        res [3];

  logic       o_valid_q;
  logic [7:0] o_a_q, o_b_q, o_c_q;
  logic       o_bv_q, o_cv_q, o_last_q;

  logic o_free, p_adv, p_free;

  // stage flow control
  assign o_free  = ~o_valid_q | pop_i;
  assign p_adv   = p_valid_q & o_free;
  assign p_free  = ~p_valid_q | o_free;
  assign q_pop_o = ~q_empty_i & p_free;

  // operands: chroma is centered in the inverse transform
  always_comb begin
    opnd[0] = $signed({1'b0, q_item_i.a});
    opnd[1] = $signed({1'b0, q_item_i.b});
    opnd[2] = $signed({1'b0, q_item_i.c});
    if (q_item_i.op == OP_INV) begin
      opnd[1] = $signed({1'b0, q_item_i.b}) - 9'sd128;
      opnd[2] = $signed({1'b0, q_item_i.c}) - 9'sd128;
    end
  end

  // products, bias folded into the first term of each channel
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        term_d[j][k] = TermW'(opnd[k]) * TermW'(coef(q_item_i.op, {2'(j), 2'(k)}));
        if (k == 0) begin
          term_d[j][k] = term_d[j][k] + offset(q_item_i.op, 2'(j));
        end
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      p_term_q <= term_d;
      p_bv_q   <= q_item_i.b_valid;
      p_cv_q   <= q_item_i.c_valid;
      p_last_q <= q_item_i.row_end;
    end
  end

  // sum, floor and clamp to 0..255
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j]   = p_term_q[j][0] + p_term_q[j][1] + p_term_q[j][2];
      whole[j] = sum[j][TermW-1:FracW];
      if (whole[j][TermW-FracW-1]) begin
        res[j] = 8'd0;
      end else if (|whole[j][TermW-FracW-2:8]) begin
        res[j] = 8'd255;
      end else begin
        res[j] = whole[j][7:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (p_adv) begin
      o_valid_q <= 1'b1;
    end else if (pop_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      o_a_q    <= res[0];
      o_b_q    <= p_bv_q ? res[1] : 8'd0;
      o_c_q    <= p_cv_q ? res[2] : 8'd0;
      o_bv_q   <= p_bv_q;
      o_cv_q   <= p_cv_q;
      o_last_q <= p_last_q;
    end
  end

  assign empty_o   = ~o_valid_q;
  assign out_a_o   = o_a_q;
  assign out_b_o   = o_b_q;
  assign out_c_o   = o_c_q;
  assign b_valid_o = o_bv_q;
  assign c_valid_o = o_cv_q;
  assign row_end_o = o_last_q;

endmodule

// ===== hw/rtl/yuv_color_converter_subsampling_top.sv =====
// ----------------------------------------------------------------------------
// yuv_color_converter_subsampling_top
// Path: a pixel accepted into an idle block passes the front stage register,
// the queue, the product stage and the result register to the result ports.
// Throughput: one pixel per cycle without stalls, set by the front stage and
// the one-pixel-per-cycle product and clamp stages; a four-entry queue and
// the result register let input and output stall independently.
// Reset: mode pass-through, line width 640, raster counters and held chroma
// cleared; the chroma line store is not cleared and needs no reset pass.
// ----------------------------------------------------------------------------
module yuv_color_converter_subsampling_top import ycs_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic                frame_start_i,
  input  logic [7:0]          chan_a_i,
  input  logic [7:0]          chan_b_i,
  input  logic [7:0]          chan_c_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_a_o,
  output logic [7:0]          out_b_o,
  output logic [7:0]          out_c_o,
  output logic                b_valid_o,
  output logic                c_valid_o,
  output logic                row_end_o
);

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  // position tracking, classification and chroma resolution
  ycs_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .frame_start_i (frame_start_i),
    .chan_a_i      (chan_a_i),
    .chan_b_i      (chan_b_i),
    .chan_c_i      (chan_c_i),
    .full_o        (full),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  // request queue
  ycs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  // color transform
  ycs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_a_o   (out_a_o),
    .out_b_o   (out_b_o),
    .out_c_o   (out_c_o),
    .b_valid_o (b_valid_o),
    .c_valid_o (c_valid_o),
    .row_end_o (row_end_o)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("request pushed into full queue");

  // the back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("request popped from empty queue");

  // a dropped chroma sample reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !b_valid_o) |-> (out_b_o == 8'd0))
    else $error("dropped U sample not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !c_valid_o) |-> (out_c_o == 8'd0))
    else $error("dropped V sample not zero");
`endif

endmodule

// ===== tb/yuv_color_converter_subsampling_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_color_converter_subsampling_checker
// Watches the configuration port and both pixel queues of the converter.
// Each accepted request is converted by a local Q16 predictor that keeps
// its own raster position, held chroma and chroma line store. Each popped
// pixel is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module yuv_color_converter_subsampling_checker import ycs_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  input  logic                full,
  input  logic                frame_start_i,
  input  logic [7:0]          chan_a_i,
  input  logic [7:0]          chan_b_i,
  input  logic [7:0]          chan_c_i,
  input  logic                empty,
  input  logic                pop,
  input  logic [7:0]          out_a_i,
  input  logic [7:0]          out_b_i,
  input  logic [7:0]          out_c_i,
  input  logic                b_valid_i,
  input  logic                c_valid_i,
  input  logic                row_end_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int LineDepth = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic       b_ok;
    logic       c_ok;
    logic       row_end;
  } pixel_t;

  // predictor copy of configuration and raster state
  logic [ModeW-1:0]      cur_mode;
  logic [LineWidthW-1:0] cur_width;
  int                    col_q;
  logic                  row_odd_q;
  logic [15:0]           held_q;
  logic [15:0]           chroma_mem [LineDepth];

  pixel_t pending_pixels [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // convert one request and advance the raster position
  function automatic pixel_t convert_pixel(input logic fs, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
    pixel_t res;
    int     w, col, pair, ia, ib, ic, hu, hv, cu, cv, ys, fy, fu, fv;
    logic   even_col;
    w = cur_width;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (fs) begin
      col_q = 0;
      row_odd_q = 1'b0;
    end
    col = col_q;
    even_col = ~col[0];
    pair = col >> 1;
    if (pair >= LineDepth) pair = LineDepth - 1;
    ia = a;
    ib = b;
    ic = c;
    res.out_a = a;
    res.out_b = b;
    res.out_c = c;
    res.b_ok = 1'b1;
    res.c_ok = 1'b1;
    res.row_end = (col + 1 >= w);

    // forward transform, floored
    fy = (19595 * ic + 38470 * ib + 7471 * ia) >>> 16;
    fu = ((128 <<< 16) - 11058 * ic - 21710 * ib + 32768 * ia) >>> 16;
    fv = ((128 <<< 16) + 32768 * ic - 27439 * ib - 5329 * ia) >>> 16;

    // inverse chroma is taken on even columns, from the line store on odd 420 rows
    if ((cur_mode == MODE_INV422 || cur_mode == MODE_INV420) && even_col) begin
      if (cur_mode == MODE_INV420 && row_odd_q) begin
        held_q = chroma_mem[pair];
      end else begin
        held_q = {c, b};
        if (cur_mode == MODE_INV420) chroma_mem[pair] = held_q;
      end
    end
    if (cur_mode == MODE_INV444) begin
      hu = ib;
      hv = ic;
    end else begin
      hu = held_q[7:0];
      hv = held_q[15:8];
    end
    cu = hu - 128;
    cv = hv - 128;
    ys = ia * 65536;

    case (cur_mode)
      MODE_FWD444, MODE_FWD422, MODE_FWD420: begin
        res.out_a = sat8(fy);
        res.out_b = sat8(fu);
        res.out_c = sat8(fv);
        // dropped chroma reads as zero with its valid low
        if (cur_mode != MODE_FWD444) begin
          if (!even_col || (cur_mode == MODE_FWD420 && row_odd_q)) begin
            res.out_b = 8'd0;
            res.b_ok = 1'b0;
          end
          if (!even_col || (cur_mode == MODE_FWD420 && !row_odd_q)) begin
            res.out_c = 8'd0;
            res.c_ok = 1'b0;
          end
        end
      end
      MODE_INV444, MODE_INV422, MODE_INV420: begin
        res.out_a = sat8((ys + 116130 * cu) >>> 16);
        res.out_b = sat8((ys - 22553 * cu - 46802 * cv) >>> 16);
        res.out_c = sat8((ys + 91881 * cv) >>> 16);
      end
      default: begin
      end
    endcase

    // raster position of the next pixel
    if (res.row_end) begin
      col_q = 0;
      row_odd_q = ~row_odd_q;
    end else begin
      col_q = col + 1;
    end
    return res;
  endfunction

  // compare popped pixels, then queue predictions for accepted requests
  always @(posedge clk_i) begin
    pixel_t want;
    if (!rst_ni) begin
      cur_mode = MODE_PASS;
      cur_width = LINE_WIDTH_RST;
      col_q = 0;
      row_odd_q = 1'b0;
      held_q = '0;
      fail_count_o = 0;
      pending_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:       cur_mode = cfg_wdata_i[ModeW-1:0];
          REG_LINE_WIDTH: cur_width = cfg_wdata_i[LineWidthW-1:0];
          default: begin
          end
        endcase
      end
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel popped with none pending, out_a", out_a_i, 0);
        end else begin
          want = pending_pixels.pop_front();
          check_field("out_a", out_a_i, want.out_a);
          check_field("out_b", out_b_i, want.out_b);
          check_field("out_c", out_c_i, want.out_c);
          check_field("b_valid", b_valid_i, want.b_ok);
          check_field("c_valid", c_valid_i, want.c_ok);
          check_field("row_end", row_end_i, want.row_end);
        end
      end
      if (push && !full) begin
        pending_pixels.push_back(convert_pixel(frame_start_i, chan_a_i, chan_b_i, chan_c_i));
      end
    end
    pending_o = pending_pixels.size();
  end

endmodule

// ===== tb/yuv_color_converter_subsampling_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_color_converter_subsampling_top_tb
// Drives pixel streams through every conversion mode and a range of line
// widths: a short corner-value pass, random phases with random stalls on
// both queues, and one wide 420 inverse frame that reaches its first odd
// row. The checker beside the converter predicts and compares.
// ----------------------------------------------------------------------------
module yuv_color_converter_subsampling_top_tb;
  import ycs_pkg::*;

  localparam int MaxWidth = 4096;
  localparam logic [ModeW-1:0] MODE_SPARE = 3'd7;
  localparam logic [23:0] CORNERS [6] = '{24'h000000, 24'hFFFFFF, 24'h00FFFF,
                                         24'hFF0000, 24'hFF00FF, 24'h00FF00};

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                frame_start_i = 1'b0;
  logic [7:0]          chan_a_i = '0;
  logic [7:0]          chan_b_i = '0;
  logic [7:0]          chan_c_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_a_o;
  logic [7:0]          out_b_o;
  logic [7:0]          out_c_o;
  logic                b_valid_o;
  logic                c_valid_o;
  logic                row_end_o;
  logic                no_gaps = 1'b0;
  int                  fail_count;
  int                  pending_count;

  yuv_color_converter_subsampling_top #(.MAX_WIDTH(MaxWidth)) dut (.*);

  yuv_color_converter_subsampling_checker #(.MAX_WIDTH(MaxWidth)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .frame_start_i (frame_start_i),
    .chan_a_i      (chan_a_i),
    .chan_b_i      (chan_b_i),
    .chan_c_i      (chan_c_i),
    .empty         (empty),
    .pop           (pop),
    .out_a_i       (out_a_o),
    .out_b_i       (out_b_o),
    .out_c_i       (out_c_o),
    .b_valid_i     (b_valid_o),
    .c_valid_i     (c_valid_o),
    .row_end_i     (row_end_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // result side stalls at random
  always @(negedge clk_i) begin
    pop <= rst_ni && (no_gaps || ($urandom_range(99) >= 37));
  end

  // hang guard
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // mostly uniform channel values, with extra weight on the extremes
  function automatic logic [7:0] rand_chan();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // both registers, back to back, junk in the unused mode bits
  task automatic write_config(input logic [ModeW-1:0] mode_val,
                              input logic [LineWidthW-1:0] width_val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MODE;
    cfg_wdata_i <= {10'($urandom), mode_val};
    @(negedge clk_i);
    cfg_idx_i <= REG_LINE_WIDTH;
    cfg_wdata_i <= width_val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one pixel request, held until accepted
  task automatic send_pixel(input logic fs, input logic [23:0] pix);
    while (!no_gaps && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    frame_start_i <= fs;
    chan_a_i <= pix[23:16];
    chan_b_i <= pix[15:8];
    chan_c_i <= pix[7:0];
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // drain, reconfigure, then stream n pixels
  task automatic run_phase(input logic [ModeW-1:0] mode_val,
                           input logic [LineWidthW-1:0] width_val,
                           input int n, input logic corner);
    logic        fs;
    logic [23:0] pix;
    push <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    write_config(mode_val, width_val);
    for (int i = 0; i < n; i++) begin
      // 420 inverse starts on a fresh frame so odd rows only read written entries
      if (i == 0) fs = corner || (mode_val == MODE_INV420) || ($urandom_range(1) == 1);
      else fs = ($urandom_range(199) == 0);
      if (corner) pix = CORNERS[(int'(mode_val) + i) % 6];
      else pix = {rand_chan(), rand_chan(), rand_chan()};
      send_pixel(fs, pix);
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [ModeW-1:0]      mode_val;
    logic [LineWidthW-1:0] width_val;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner values in every mode, rows of two pixels
    for (int m = 0; m < 8; m++) begin
      run_phase(ModeW'(m), LineWidthW'(m % 3), 3, 1'b1);
    end

    // random phases over all modes and a spread of widths
    for (int r = 0; r < 12; r++) begin
      mode_val = ModeW'((r * 3) % 8);
      if (r == 4) width_val = 13'd0;
      else if (r == 9) width_val = 13'd1;
      else if (r == 7) width_val = 13'd4097;
      else width_val = LineWidthW'($urandom_range(2, 24));
      no_gaps <= (r == 5);
      run_phase(mode_val, width_val, 100, 1'b0);
    end
    no_gaps <= 1'b0;

    // wide 420 inverse frame, into its first odd row
    run_phase(MODE_INV420, 13'd160, 200, 1'b0);
    run_phase(MODE_SPARE, LINE_WIDTH_RST, 20, 1'b0);

    push <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== yuv_color_converter_subsampling_top.f =====
hw/rtl/ycs_pkg.sv
hw/rtl/ycs_ram.sv
hw/rtl/ycs_fifo.sv
hw/rtl/ycs_front.sv
hw/rtl/ycs_back.sv
hw/rtl/yuv_color_converter_subsampling_top.sv
tb/yuv_color_converter_subsampling_checker.sv
tb/yuv_color_converter_subsampling_top_tb.sv
